### design/ira_pkg.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator package
// Shared widths, command and status codes, the table entry and the ring
// operation that the controller broadcasts to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

   localparam int MAX_RANGES = 64;
   localparam int ADDR_W     = 32;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int IDX_W      = $clog2(MAX_RANGES);

   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_CHECK   = 2'd1;
   localparam logic [1:0] CMD_ALLOC   = 2'd2;

   localparam logic [2:0] STAT_DONE    = 3'd0;
   localparam logic [2:0] STAT_OVERLAP = 3'd1;
   localparam logic [2:0] STAT_FREE    = 3'd2;
   localparam logic [2:0] STAT_NOROOM  = 3'd3;
   localparam logic [2:0] STAT_FULL    = 3'd4;

   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_RANGES);

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
   } entry_type;

   // One step of the elastic ring. Cells below lim-1 take their right
   // neighbor; the cells at x_pos and y_pos load the emitted entries.
   typedef struct packed {
      logic             shift;
      logic [CNT_W-1:0] lim;
      logic             x_en;
      logic [CNT_W-1:0] x_pos;
      logic             y_en;
      logic [CNT_W-1:0] y_pos;
      entry_type        x;
      entry_type        y;
   } ring_op_type;

endpackage

`default_nettype wire

### design/ira_intf.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator channels
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ira_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic [ira_pkg::ADDR_W-1:0] start_addr;
   logic [ira_pkg::ADDR_W-1:0] range_length;
   logic [ira_pkg::ADDR_W-1:0] align_mask;

   modport source (output valid, cmd, start_addr, range_length, align_mask, input ready);
   modport sink (input valid, cmd, start_addr, range_length, align_mask, output ready);
endinterface

interface ira_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                status;
   logic [ira_pkg::ADDR_W-1:0] granted_addr;

   modport source (output valid, status, granted_addr, input ready);
   modport sink (input valid, status, granted_addr, output ready);
endinterface

`default_nettype wire

### design/ira_cell.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator cell
// Holds one table entry; shifts toward the head or loads an emitted entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_cell (
   input  wire logic                      clock,
   input  wire logic [ira_pkg::IDX_W-1:0] cell_idx,
   input  wire ira_pkg::entry_type        right_in,
   input  wire ira_pkg::ring_op_type      op,
   output      ira_pkg::entry_type        data_out
);

   ira_pkg::entry_type              data_ff, data_in;
   logic [ira_pkg::CNT_W-1:0]       idx_w;

   assign idx_w = ira_pkg::CNT_W'(cell_idx);

   always_comb begin
      data_in = data_ff;
      priority if (op.shift && ((idx_w + ira_pkg::CNT_W'(1)) < op.lim)) begin
         data_in = right_in;
      end else if (op.x_en && (idx_w == op.x_pos)) begin
         data_in = op.x;
      end else if (op.y_en && (idx_w == op.y_pos)) begin
         data_in = op.y;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

### design/ira_ctrl.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator controller
// Walks the ring head one entry per cycle and emits the edited table.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ira_req_if.sink                   req_ch,
   ira_rsp_if.source                 rsp_ch,
   input  wire ira_pkg::entry_type   head,
   output      ira_pkg::ring_op_type ring_op
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RSCAN   = 4'd1;
   localparam logic [3:0] S_RMERGE  = 4'd2;
   localparam logic [3:0] S_RCOPY   = 4'd3;
   localparam logic [3:0] S_CSCAN   = 4'd4;
   localparam logic [3:0] S_ASCAN   = 4'd5;
   localparam logic [3:0] S_ADECIDE = 4'd6;
   localparam logic [3:0] S_FINISH  = 4'd7;

   localparam int AW = ira_pkg::ADDR_W;
   localparam int CW = ira_pkg::CNT_W;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;

   logic [AW-1:0] s_ff, s_in;
   logic [AW-1:0] e_ff, e_in;
   logic [AW-1:0] l_ff, l_in;
   logic [AW-1:0] al_ff, al_in;
   logic [AW-1:0] sta_ff, sta_in;
   logic [AW-1:0] acc_s_ff, acc_s_in;
   logic [AW-1:0] acc_e_ff, acc_e_in;
   logic [AW-1:0] acc_l_ff, acc_l_in;
   logic          found_ff, found_in;
   logic          alloc_ff, alloc_in;
   logic [2:0]    stat_ff, stat_in;

   logic          accept;
   logic [AW-1:0] os, ol, et, et1, sta_l;
   logic [AW:0]   req_sum, sta_sum;
   logic [CW-1:0] cnt_m1;
   logic          full;
   ira_pkg::entry_type acc_ent, new_ent;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign accept              = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.granted_addr = rsp_addr_ff;

   // Stored ranges never wrap, so the exclusive end fits the address width.
   assign os      = head.start;
   assign ol      = head.len;
   assign et      = os + ol;
   assign et1     = os + ol - AW'(1);
   assign sta_l   = sta_ff + l_ff;
   assign req_sum = {1'b0, req_ch.start_addr} + {1'b0, req_ch.range_length};
   assign sta_sum = {1'b0, sta_ff} + {1'b0, l_ff};
   assign cnt_m1  = cnt_ff - CW'(1);
   assign full    = (cnt_ff == ira_pkg::CNT_MAX);
   assign acc_ent = '{start: acc_s_ff, len: acc_l_ff};
   assign new_ent = '{start: s_ff, len: l_ff};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      l_in          = l_ff;
      al_in         = al_ff;
      sta_in        = sta_ff;
      acc_s_in      = acc_s_ff;
      acc_e_in      = acc_e_ff;
      acc_l_in      = acc_l_ff;
      found_in      = found_ff;
      alloc_in      = alloc_ff;
      stat_in       = stat_ff;
      ring_op       = '0;
      ring_op.lim   = cnt_ff;
      ring_op.x_pos = cnt_m1;
      ring_op.y_pos = cnt_ff;
      ring_op.x     = head;
      ring_op.y     = head;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rem_in   = cnt_ff;
               found_in = 1'b0;
               alloc_in = 1'b0;
               s_in     = req_ch.start_addr;
               l_in     = req_ch.range_length;
               al_in    = req_ch.align_mask;
               sta_in   = req_ch.start_addr;
               stat_in  = ira_pkg::STAT_DONE;
               priority if (req_ch.cmd == ira_pkg::CMD_RESERVE) begin
                  if (req_ch.range_length == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_RSCAN;
                     if (req_sum[AW]) begin
                        e_in = ira_pkg::ADDR_TOP;
                        l_in = ira_pkg::ADDR_TOP - req_ch.start_addr;
                     end else begin
                        e_in = req_sum[AW-1:0];
                     end
                  end
               end else if (req_ch.cmd == ira_pkg::CMD_CHECK) begin
                  stat_in = ira_pkg::STAT_FREE;
                  e_in    = req_sum[AW-1:0] - AW'(1);
                  if (req_ch.range_length == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_CSCAN;
                  end
               end else if (req_ch.cmd == ira_pkg::CMD_ALLOC) begin
                  alloc_in = 1'b1;
                  state_in = S_ASCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_RSCAN: begin
            if (rem_ff == '0) begin
               if (full) begin
                  stat_in = ira_pkg::STAT_FULL;
               end else begin
                  ring_op.x_en  = 1'b1;
                  ring_op.x_pos = cnt_ff;
                  ring_op.x     = new_ent;
                  cnt_in        = cnt_ff + CW'(1);
               end
               state_in = S_FINISH;
            end else begin
               rem_in        = rem_ff - CW'(1);
               ring_op.shift = 1'b1;
               priority if ((s_ff >= os) && (e_ff <= et)) begin
                  ring_op.x_en = 1'b1;
                  state_in     = S_RCOPY;
               end else if (s_ff == os) begin
                  acc_s_in = s_ff;
                  acc_e_in = e_ff;
                  acc_l_in = l_ff;
                  cnt_in   = cnt_m1;
                  state_in = S_RMERGE;
               end else if (s_ff < os) begin
                  state_in = S_RCOPY;
                  priority if (e_ff >= et) begin
                     acc_s_in = s_ff;
                     acc_e_in = e_ff;
                     acc_l_in = l_ff;
                     cnt_in   = cnt_m1;
                     state_in = S_RMERGE;
                  end else if (e_ff >= os) begin
                     ring_op.x_en = 1'b1;
                     ring_op.x    = '{start: s_ff, len: et - s_ff};
                  end else if (full) begin
                     ring_op.x_en = 1'b1;
                     stat_in      = ira_pkg::STAT_FULL;
                  end else begin
                     ring_op.x_en = 1'b1;
                     ring_op.x    = new_ent;
                     ring_op.y_en = 1'b1;
                     cnt_in       = cnt_ff + CW'(1);
                  end
               end else if (s_ff <= et) begin
                  acc_s_in = os;
                  acc_e_in = e_ff;
                  acc_l_in = e_ff - os;
                  cnt_in   = cnt_m1;
                  state_in = S_RMERGE;
               end else begin
                  ring_op.x_en = 1'b1;
               end
            end
         end

         S_RMERGE: begin
            if (rem_ff == '0) begin
               ring_op.x_en  = 1'b1;
               ring_op.x_pos = cnt_ff;
               ring_op.x     = acc_ent;
               cnt_in        = cnt_ff + CW'(1);
               state_in      = S_FINISH;
            end else begin
               rem_in        = rem_ff - CW'(1);
               ring_op.shift = 1'b1;
               if (os > acc_e_ff) begin
                  // The merged range is complete; emit it ahead of this entry.
                  ring_op.x_en = 1'b1;
                  ring_op.x    = acc_ent;
                  ring_op.y_en = 1'b1;
                  cnt_in       = cnt_ff + CW'(1);
                  state_in     = S_RCOPY;
               end else begin
                  cnt_in = cnt_m1;
                  if (acc_e_ff < et) begin
                     acc_e_in = et;
                     acc_l_in = et - acc_s_ff;
                  end
               end
            end
         end

         S_RCOPY: begin
            if (rem_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               rem_in        = rem_ff - CW'(1);
               ring_op.shift = 1'b1;
               ring_op.x_en  = 1'b1;
            end
         end

         S_CSCAN: begin
            if (rem_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               rem_in        = rem_ff - CW'(1);
               ring_op.shift = 1'b1;
               ring_op.x_en  = 1'b1;
               if (!found_ff) begin
                  if (((s_ff >= os) && (s_ff <= et1)) || ((e_ff >= os) && (e_ff <= et1)) ||
                      ((s_ff < os) && (e_ff > et1))) begin
                     stat_in  = ira_pkg::STAT_OVERLAP;
                     found_in = 1'b1;
                  end else if (e_ff < os) begin
                     found_in = 1'b1;
                  end
               end
            end
         end

         S_ASCAN: begin
            if (rem_ff == '0) begin
               state_in = S_ADECIDE;
            end else begin
               rem_in        = rem_ff - CW'(1);
               ring_op.shift = 1'b1;
               ring_op.x_en  = 1'b1;
               if (!found_ff) begin
                  if ((l_ff == '0) ? (sta_ff < os) : (sta_l <= os)) begin
                     found_in = 1'b1;
                  end else if (et >= sta_ff) begin
                     sta_in = (et + al_ff) & ~al_ff;
                  end
               end
            end
         end

         S_ADECIDE: begin
            s_in   = sta_ff;
            e_in   = sta_sum[AW-1:0];
            rem_in = cnt_ff;
            if (sta_sum[AW]) begin
               stat_in  = ira_pkg::STAT_NOROOM;
               state_in = S_FINISH;
            end else if (l_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_RSCAN;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_addr_in   = (alloc_ff && (stat_ff == ira_pkg::STAT_DONE)) ? s_ff : '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      l_ff          <= l_in;
      al_ff         <= al_in;
      sta_ff        <= sta_in;
      acc_s_ff      <= acc_s_in;
      acc_e_ff      <= acc_e_in;
      acc_l_ff      <= acc_l_in;
      found_ff      <= found_in;
      alloc_ff      <= alloc_in;
      stat_ff       <= stat_in;
   end

endmodule

`default_nettype wire

### design/interval_reserve_allocator.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator
// Sorted table of reserved address ranges with reserve, check and allocate.
// ----------------------------------------------------------------------------
// Commands arrive on req_ch (cmd, start_addr, range_length, align_mask) and
// each produces exactly one response on rsp_ch (status, granted_addr).
// The table lives in a row of cells that forms an elastic ring: in each step
// of a pass the controller reads the head cell, and the cells shift one step
// toward the head while the edited entry (or two, for an insertion, or none,
// for a merge) is written behind the last live entry. One pass visits every
// entry once. Reserve and check make one pass, allocate a search pass then a
// reserve pass; the table holds at most 64 stored ranges. A zero-length
// reserve or check answers without a pass. One command is in flight at a time.
// A finished response waits in an output register; the next command is
// accepted while it waits, and a stalled receiver only holds back the
// completion of that next command.
// Reset empties the table at once; entry contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_reserve_allocator (
   input  wire logic clock,
   input  wire logic reset,
   ira_req_if.sink   req_ch,
   ira_rsp_if.source rsp_ch
);

   ira_pkg::entry_type   cell_data [ira_pkg::MAX_RANGES];
   ira_pkg::ring_op_type ring_op;

   ira_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .head    (cell_data[0]),
      .ring_op (ring_op)
   );

   for (genvar g = 0; g < ira_pkg::MAX_RANGES; g++) begin : g_cell
      ira_pkg::entry_type right;
      if (g == ira_pkg::MAX_RANGES - 1) begin : g_last
         assign right = '0;
      end else begin : g_mid
         assign right = cell_data[g+1];
      end
      ira_cell u_cell (
         .clock    (clock),
         .cell_idx (ira_pkg::IDX_W'(g)),
         .right_in (right),
         .op       (ring_op),
         .data_out (cell_data[g])
      );
   end

endmodule

`default_nettype wire

### tb/ira_checker.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator checker
// Watches the command and response channels, keeps its own copy of the range
// table, predicts the response of every accepted command and compares it
// field by field with the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ira_checker (
   input  wire logic clock,
   input  wire logic reset,
   ira_req_if        req_ch,
   ira_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending
);

   typedef struct {
      logic [2:0]                 status;
      logic [ira_pkg::ADDR_W-1:0] addr;
   } resp_type;

   logic [ira_pkg::ADDR_W-1:0] tbl_start [ira_pkg::MAX_RANGES];
   logic [ira_pkg::ADDR_W-1:0] tbl_len   [ira_pkg::MAX_RANGES];
   int                         tbl_used;
   resp_type                   expected_resp [$];

   function automatic logic [2:0] insert_range(int pos, logic [ira_pkg::ADDR_W-1:0] s,
                                               logic [ira_pkg::ADDR_W-1:0] l);
      if (tbl_used >= ira_pkg::MAX_RANGES || pos > tbl_used) return ira_pkg::STAT_FULL;
      for (int j = tbl_used; j > pos; j--) begin
         tbl_start[j] = tbl_start[j-1];
         tbl_len[j]   = tbl_len[j-1];
      end
      tbl_start[pos] = s;
      tbl_len[pos]   = l;
      tbl_used++;
      return ira_pkg::STAT_DONE;
   endfunction

   // Folds the following entries that entry i reaches or touches into it.
   function automatic void absorb_following(int i);
      int                         k;
      int                         gone;
      logic [ira_pkg::ADDR_W-1:0] e_i;
      logic [ira_pkg::ADDR_W-1:0] e_k;
      k = i + 1;
      while (k < tbl_used) begin
         e_i = tbl_start[i] + tbl_len[i];
         e_k = tbl_start[k] + tbl_len[k];
         if (tbl_start[k] > e_i) break;
         if (e_i < e_k) tbl_len[i] = tbl_len[i] + tbl_len[k] - (e_i - tbl_start[k]);
         k++;
      end
      if (k > i + 1) begin
         gone = k - (i + 1);
         for (int j = i + 1; j + gone < tbl_used; j++) begin
            tbl_start[j] = tbl_start[j+gone];
            tbl_len[j]   = tbl_len[j+gone];
         end
         tbl_used -= gone;
      end
   endfunction

   function automatic logic [2:0] reserve_range(logic [ira_pkg::ADDR_W-1:0] s,
                                                logic [ira_pkg::ADDR_W-1:0] l);
      logic [ira_pkg::ADDR_W-1:0] e;
      logic [ira_pkg::ADDR_W-1:0] os;
      logic [ira_pkg::ADDR_W-1:0] et;
      if (l == 0) return ira_pkg::STAT_DONE;
      e = s + l;
      if (e < s) begin
         e = ira_pkg::ADDR_TOP;
         l = ira_pkg::ADDR_TOP - s;
      end
      for (int i = 0; i < tbl_used; i++) begin
         os = tbl_start[i];
         et = os + tbl_len[i];
         if (et < os) begin
            et = ira_pkg::ADDR_TOP;
            tbl_len[i] = ira_pkg::ADDR_TOP - os;
         end
         if (s >= os && e <= et) return ira_pkg::STAT_DONE;
         if (s == os) begin
            tbl_len[i] = l;
            absorb_following(i);
            return ira_pkg::STAT_DONE;
         end
         if (s < os) begin
            if (e >= et) begin
               tbl_start[i] = s;
               tbl_len[i]   = l;
               absorb_following(i);
               return ira_pkg::STAT_DONE;
            end
            if (e >= os) begin
               tbl_len[i]   = tbl_len[i] + (os - s);
               tbl_start[i] = s;
               return ira_pkg::STAT_DONE;
            end
            return insert_range(i, s, l);
         end
         if (s <= et) begin
            tbl_len[i] = e - os;
            absorb_following(i);
            return ira_pkg::STAT_DONE;
         end
      end
      return insert_range(tbl_used, s, l);
   endfunction

   function automatic logic [2:0] probe_overlap(logic [ira_pkg::ADDR_W-1:0] s,
                                                logic [ira_pkg::ADDR_W-1:0] l);
      logic [ira_pkg::ADDR_W-1:0] e;
      logic [ira_pkg::ADDR_W-1:0] os;
      logic [ira_pkg::ADDR_W-1:0] et;
      if (l == 0) return ira_pkg::STAT_FREE;
      e = s + l - 1;
      for (int i = 0; i < tbl_used; i++) begin
         os = tbl_start[i];
         et = os + tbl_len[i] - 1;
         if (s >= os && s <= et) return ira_pkg::STAT_OVERLAP;
         if (e >= os && e <= et) return ira_pkg::STAT_OVERLAP;
         if (s < os && e > et) return ira_pkg::STAT_OVERLAP;
         if (e < os) break;
      end
      return ira_pkg::STAT_FREE;
   endfunction

   function automatic resp_type serve_command(logic [1:0] cmd,
                                              logic [ira_pkg::ADDR_W-1:0] s,
                                              logic [ira_pkg::ADDR_W-1:0] l,
                                              logic [ira_pkg::ADDR_W-1:0] m);
      resp_type                   r;
      logic [ira_pkg::ADDR_W-1:0] cand;
      logic [ira_pkg::ADDR_W-1:0] os;
      logic [ira_pkg::ADDR_W-1:0] oe;
      logic [ira_pkg::ADDR_W-1:0] cand_end;
      r.status = ira_pkg::STAT_DONE;
      r.addr   = '0;
      case (cmd)
         ira_pkg::CMD_RESERVE: r.status = reserve_range(s, l);
         ira_pkg::CMD_CHECK:   r.status = probe_overlap(s, l);
         ira_pkg::CMD_ALLOC: begin
            cand = s;
            for (int i = 0; i < tbl_used; i++) begin
               os = tbl_start[i];
               oe = os + tbl_len[i];
               cand_end = cand + l;
               if (l == 0) begin
                  if (cand < os) break;
               end else if (cand_end <= os) begin
                  break;
               end
               if (oe >= cand) cand = (oe + m) & ~m;
            end
            cand_end = cand + l;
            if (cand_end < cand) begin
               r.status = ira_pkg::STAT_NOROOM;
            end else begin
               r.status = reserve_range(cand, l);
               if (r.status == ira_pkg::STAT_DONE) r.addr = cand;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      resp_type want;
      if (reset) begin
         tbl_used = 0;
         expected_resp.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_resp.push_back(serve_command(req_ch.cmd, req_ch.start_addr,
                                                  req_ch.range_length, req_ch.align_mask));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_resp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response status=%0d addr=%h", $realtime,
                           rsp_ch.status, rsp_ch.granted_addr);
            end else begin
               want = expected_resp.pop_front();
               if (want.status !== rsp_ch.status || want.addr !== rsp_ch.granted_addr) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch expected status=%0d addr=%h, got status=%0d addr=%h",
                              $realtime, want.status, want.addr, rsp_ch.status,
                              rsp_ch.granted_addr);
               end
            end
         end
      end
      pending = expected_resp.size();
   end

   initial fail_count = 0;

endmodule

### tb/interval_reserve_allocator_tb.sv
// ----------------------------------------------------------------------------
// Interval reserve allocator testbench
// Sends directed and random reserve, check, allocate and unused commands in
// bursts while the response side stalls on its own pattern; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_reserve_allocator_tb;

   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1080;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   int   burst_left;

   ira_req_if req_ch ();
   ira_rsp_if rsp_ch ();

   interval_reserve_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ira_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver alternates between always-ready stretches and random stalls.
   always @(posedge clock) begin
      int mode_left;
      int mode;
      if (mode_left <= 0) begin
         mode_left = $urandom_range(5, 80);
         mode      = $urandom_range(0, 2);
      end
      mode_left--;
      case (mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   task automatic send_cmd(logic [1:0] cmd, logic [ira_pkg::ADDR_W-1:0] s,
                           logic [ira_pkg::ADDR_W-1:0] l, logic [ira_pkg::ADDR_W-1:0] m);
      int gap;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.start_addr   <= s;
      req_ch.range_length <= l;
      req_ch.align_mask   <= m;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [ira_pkg::ADDR_W-1:0] pick_mask();
      return (32'd1 << $urandom_range(0, 8)) - 32'd1;
   endfunction

   initial begin
      int         kind;
      logic [1:0] cmd;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = ira_pkg::CMD_RESERVE;
      req_ch.start_addr   = '0;
      req_ch.range_length = '0;
      req_ch.align_mask   = '0;
      burst_left          = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero lengths, overlaps, merges, wrap at the top.
      send_cmd(ira_pkg::CMD_RESERVE, 32'h100, 32'h0, 32'h0);
      send_cmd(ira_pkg::CMD_CHECK, 32'h100, 32'h0, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'h100, 32'h40, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'h200, 32'h40, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'h140, 32'hC0, 32'h0);
      send_cmd(ira_pkg::CMD_CHECK, 32'h13F, 32'h1, 32'h0);
      send_cmd(ira_pkg::CMD_CHECK, 32'h240, 32'h10, 32'h0);
      send_cmd(ira_pkg::CMD_CHECK, 32'h80, 32'h400, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'h50, 32'h10, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'h40, 32'h400, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0);
      send_cmd(ira_pkg::CMD_CHECK, 32'hFFFF_FFF0, 32'h20, 32'h0);
      send_cmd(ira_pkg::CMD_ALLOC, 32'h0, 32'h10, 32'h0);
      send_cmd(ira_pkg::CMD_ALLOC, 32'h0, 32'h10, 32'hFF);
      send_cmd(ira_pkg::CMD_ALLOC, 32'h0, 32'h0, 32'hF);
      send_cmd(ira_pkg::CMD_ALLOC, 32'hFFFF_FE00, 32'h200, 32'h0);
      send_cmd(ira_pkg::CMD_ALLOC, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(ira_pkg::CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_cmd(ira_pkg::CMD_RESERVE, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_cmd(ira_pkg::CMD_CHECK, 32'h1234_5678, 32'h1, 32'h0);

      // Random part. Most commands work in a small window so that ranges
      // pile up, merge and fill the table; some are full-width noise.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 300 == 0)
            send_cmd(ira_pkg::CMD_RESERVE, 32'h0, 32'hFFFF_FFFF, 32'h0);
         kind = $urandom_range(0, 99);
         cmd  = 2'($urandom_range(0, 2));
         if ((n / 150) % 2 == 0 && kind < 60)
            // Sparse small ranges drive the table toward full.
            send_cmd(cmd, 32'h1000_0000 + 8 * $urandom_range(0, 255), $urandom_range(1, 4),
                     pick_mask());
         else if (kind < 85)
            send_cmd(cmd, 32'h1000_0000 + $urandom_range(0, 4095), $urandom_range(0, 96),
                     pick_mask());
         else if (kind < 92)
            send_cmd(cmd, 32'hFFFF_FFFF - $urandom_range(0, 512), $urandom_range(0, 1024),
                     pick_mask());
         else
            send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("interval_reserve_allocator_tb: PASS");
      else
         $display("interval_reserve_allocator_tb: FAIL");
      $finish;
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("interval_reserve_allocator_tb: FAIL");
      $finish;
   end

endmodule
